FILE: rtl/cbor_pkg.sv
// ----------------------------------------------------------------------------
// cbor_pkg
// Shared constants and types of the CBOR item scanner.
// ----------------------------------------------------------------------------
package cbor_pkg;

    localparam int MAX_NEST_DEF = 8;
    localparam int LEN_BITS_DEF = 16;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_TRUNC = 3'd1;
    localparam logic [2:0] ERR_INFO  = 3'd2;
    localparam logic [2:0] ERR_TAG   = 3'd3;
    localparam logic [2:0] ERR_DEEP  = 3'd4;
    localparam logic [2:0] ERR_COUNT = 3'd5;

    localparam logic [2:0] MAJ_BSTR  = 3'd2;
    localparam logic [2:0] MAJ_TSTR  = 3'd3;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;
    localparam logic [2:0] MAJ_MAP   = 3'd5;
    localparam logic [2:0] MAJ_TAG   = 3'd6;

    localparam logic [4:0] INFO_ARG1 = 5'd24;
    localparam logic [4:0] INFO_ARG8 = 5'd27;

    // Datapath operation selected by the controller
    typedef struct packed {
        logic clear;      // start of a new item
        logic in_head;    // decode this byte as a head
        logic in_arg;     // shift this byte into the argument
        logic in_skip;    // count down payload
        logic commit;     // write datapath state
    } cbor_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] status;
        logic       to_arg;
        logic       to_skip;
    } cbor_stat_t;

endpackage

FILE: rtl/cbor_ctrl.sv
// ----------------------------------------------------------------------------
// cbor_ctrl
// Scan phase controller and output register handshake.
// ----------------------------------------------------------------------------
module cbor_ctrl
    import cbor_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       start,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  cbor_stat_t stat,
    output cbor_cmd_t  cmd
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_ARG  = 2'd2;
    localparam logic [1:0] PH_SKIP = 2'd3;

    logic [1:0] phase_reg, phase_next, ph_eff;
    logic       valid_reg;
    logic       take;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign take      = in_valid && in_ready;
    assign ph_eff    = start ? PH_HEAD : phase_reg;

    // Decode operation for this word
    always_comb
    begin
        cmd.clear   = start;
        cmd.in_head = ph_eff == PH_HEAD;
        cmd.in_arg  = ph_eff == PH_ARG;
        cmd.in_skip = ph_eff == PH_SKIP;
        cmd.commit  = take;
        phase_next  = ph_eff;
        unique case (ph_eff) inside
            PH_IDLE: phase_next = PH_IDLE;
            PH_HEAD, PH_ARG, PH_SKIP:
            begin
                if (stat.to_arg)
                    phase_next = PH_ARG;
                else if (stat.to_skip)
                    phase_next = PH_SKIP;
                else
                    phase_next = PH_HEAD;
            end
            default: phase_next = PH_IDLE;
        endcase
        if (stat.status != ST_BUSY)
            phase_next = PH_IDLE;
    end

    // Advance phase and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                phase_reg <= phase_next;
            if (take)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/cbor_dpath.sv
// ----------------------------------------------------------------------------
// cbor_dpath
// Head decode, argument shift, payload count and nesting stack.
// ----------------------------------------------------------------------------
module cbor_dpath
    import cbor_pkg::*;
#(
    parameter int MAX_NEST = MAX_NEST_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cbor_cmd_t   cmd,
    input  logic [7:0]  data_byte,
    input  logic [15:0] bytes_after,
    output cbor_stat_t  stat,
    output logic [1:0]  scan_status,
    output logic [2:0]  error_kind,
    output logic        head_done,
    output logic [2:0]  head_major,
    output logic [63:0] head_argument,
    output logic [3:0]  nest_level
);

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam int CW = LEN_BITS + 1;

    logic [63:0]       acc_reg, acc_next;
    logic [3:0]        need_reg, need_next;
    logic [2:0]        pmaj_reg, pmaj_next;
    logic [LEN_BITS-1:0] skip_reg, skip_next;
    logic [DW-1:0]     dep_reg, dep_next;
    logic [CW-1:0]     kids_reg [MAX_NEST];
    logic [MAX_NEST-1:0] dec_mask, kids_one;
    logic              push_en;
    logic [CW-1:0]     push_val;

    logic [2:0]  maj, hmaj;
    logic [4:0]  info;
    logic [63:0] harg, count;
    logic [3:0]  needb;
    logic        hcomp, fin, fin_top;
    logic [DW-1:0] dep_cur, fin_dep;
    logic [1:0]  st;
    logic [2:0]  err;
    logic [4:0]  nshift;

    assign maj  = data_byte[7:5];
    assign info = data_byte[4:0];
    assign dep_cur = cmd.clear ? '0 : dep_reg;

    // Children-done compare per level, used by the pop cascade
    always_comb
    begin
        for (int i = 0; i < MAX_NEST; i++)
            kids_one[i] = kids_reg[i] == CW'(1);
    end

    // Pop cascade: drop each innermost level whose last child ends
    always_comb
    begin
        fin_dep = dep_cur;
        fin_top = 1'b1;
        for (int i = MAX_NEST - 1; i >= 0; i--)
        begin
            if (fin_top && DW'(i) < dep_cur)
            begin
                if (kids_one[i])
                    fin_dep = DW'(i);
                else
                    fin_top = 1'b0;
            end
        end
        // Count down every popped level and the level where the cascade stops
        dec_mask = '0;
        for (int i = 0; i < MAX_NEST; i++)
            if (DW'(i) < dep_cur &&
                (DW'(i) >= fin_dep || (!fin_top && DW'(i + 1) == fin_dep)))
                dec_mask[i] = 1'b1;
    end

    // Decode the word and complete heads
    always_comb
    begin
        acc_next  = acc_reg;
        need_next = need_reg;
        pmaj_next = pmaj_reg;
        skip_next = skip_reg;
        dep_next  = dep_cur;
        st = ST_BUSY;
        err = ERR_NONE;
        hcomp = 1'b0;
        hmaj = '0;
        harg = '0;
        fin = 1'b0;
        push_en = 1'b0;
        count = '0;
        nshift = info - INFO_ARG1;
        needb = 4'd1 << nshift[1:0];
        stat.to_arg = 1'b0;
        stat.to_skip = 1'b0;
        if (cmd.clear)
        begin
            acc_next = '0;
            need_next = '0;
            pmaj_next = '0;
            skip_next = '0;
        end
        if (cmd.in_head)
        begin
            if (info < INFO_ARG1)
            begin
                hcomp = 1'b1;
                hmaj = maj;
                harg = {59'd0, info};
            end
            else if (info <= INFO_ARG8)
            begin
                if (16'(needb) > bytes_after)
                begin
                    st = ST_ERR;
                    err = ERR_TRUNC;
                end
                else
                begin
                    pmaj_next = maj;
                    acc_next = '0;
                    need_next = needb;
                    stat.to_arg = 1'b1;
                end
            end
            else
            begin
                st = ST_ERR;
                err = ERR_INFO;
            end
        end
        else if (cmd.in_arg)
        begin
            acc_next = {acc_reg[55:0], data_byte};
            need_next = need_reg - 4'd1;
            if (need_next == 4'd0)
            begin
                hcomp = 1'b1;
                hmaj = pmaj_reg;
                harg = acc_next;
            end
            else
                stat.to_arg = 1'b1;
        end
        else if (cmd.in_skip)
        begin
            skip_next = skip_reg - LEN_BITS'(1);
            if (skip_next == '0)
                fin = 1'b1;
            else
                stat.to_skip = 1'b1;
        end
        if (hcomp)
        begin
            case (hmaj) inside
                MAJ_TAG:
                begin
                    st = ST_ERR;
                    err = ERR_TAG;
                end
                MAJ_BSTR, MAJ_TSTR:
                begin
                    if (harg > {48'd0, bytes_after})
                    begin
                        st = ST_ERR;
                        err = ERR_TRUNC;
                    end
                    else if (harg != 64'd0)
                    begin
                        skip_next = LEN_BITS'(harg);
                        stat.to_skip = 1'b1;
                    end
                end
                MAJ_ARRAY:
                begin
                    if (harg > {48'd0, bytes_after})
                    begin
                        st = ST_ERR;
                        err = ERR_COUNT;
                    end
                    else
                        count = harg;
                end
                MAJ_MAP:
                begin
                    if (harg > {49'd0, bytes_after[15:1]})
                    begin
                        st = ST_ERR;
                        err = ERR_COUNT;
                    end
                    else
                        count = {harg[62:0], 1'b0};
                end
                default: count = '0;
            endcase
            if (st == ST_BUSY && !stat.to_skip)
            begin
                if (count != 64'd0)
                begin
                    if (dep_cur >= DW'(MAX_NEST))
                    begin
                        st = ST_ERR;
                        err = ERR_DEEP;
                    end
                    else
                    begin
                        push_en = 1'b1;
                        dep_next = dep_cur + DW'(1);
                    end
                end
                else
                    fin = 1'b1;
            end
        end
        if (fin)
        begin
            dep_next = fin_dep;
            if (fin_top)
                st = ST_DONE;
        end
        if (st == ST_BUSY && bytes_after == 16'd0)
        begin
            st = ST_ERR;
            err = ERR_TRUNC;
        end
        push_val = CW'(count);
        stat.status = st;
    end

    // Hold datapath state and the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dep_reg <= '0;
        else if (cmd.commit && (cmd.clear || cmd.in_head || cmd.in_arg || cmd.in_skip))
            dep_reg <= dep_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            acc_reg  <= acc_next;
            need_reg <= need_next;
            pmaj_reg <= pmaj_next;
            skip_reg <= skip_next;
            for (int i = 0; i < MAX_NEST; i++)
            begin
                if (push_en && DW'(i) == dep_cur)
                    kids_reg[i] <= push_val;
                else if (fin && dec_mask[i])
                    kids_reg[i] <= kids_reg[i] - CW'(1);
            end
            if (cmd.in_head || cmd.in_arg || cmd.in_skip)
            begin
                scan_status   <= st;
                error_kind    <= err;
                head_done     <= hcomp;
                head_major    <= hmaj;
                head_argument <= harg;
                nest_level    <= 4'(dep_next);
            end
            else
            begin
                scan_status   <= ST_BUSY;
                error_kind    <= ERR_NONE;
                head_done     <= 1'b0;
                head_major    <= '0;
                head_argument <= '0;
                nest_level    <= '0;
            end
        end
    end

endmodule

FILE: rtl/cbor_item_scan_skipper_unit.sv
// ----------------------------------------------------------------------------
// cbor_item_scan_skipper_unit
// Scans one CBOR data item a byte at a time and checks well-formedness.
// ----------------------------------------------------------------------------
// One byte word is taken per clock and each gives one registered result
// word; a new byte enters in the same cycle that the last result leaves, so
// with the sink always ready the rate is one byte per cycle, and a stalled
// result holds the input off until it is taken. The nesting stack pop
// is resolved in the same cycle by a parallel compare of all open levels.
module cbor_item_scan_skipper_unit
    import cbor_pkg::*;
#(
    parameter int MAX_NEST = MAX_NEST_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_byte[7:0], bytes_after[23:8]
    input  logic        s_axis_tuser,  // start_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scan_status[1:0], error_kind[4:2], head_major[7:5], head_argument[71:8],
    // nest_level[75:72], zero fill
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tuser   // head_done
);

    cbor_cmd_t  cmd;
    cbor_stat_t stat;
    logic [1:0]  scan_status;
    logic [2:0]  error_kind, head_major;
    logic [63:0] head_argument;
    logic [3:0]  nest_level;

    cbor_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .start     (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cbor_dpath #(.MAX_NEST(MAX_NEST), .LEN_BITS(LEN_BITS)) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .data_byte     (s_axis_tdata[7:0]),
        .bytes_after   (s_axis_tdata[23:8]),
        .stat          (stat),
        .scan_status   (scan_status),
        .error_kind    (error_kind),
        .head_done     (m_axis_tuser),
        .head_major    (head_major),
        .head_argument (head_argument),
        .nest_level    (nest_level)
    );

    assign m_axis_tdata = {4'd0, nest_level, head_argument, head_major, error_kind,
                           scan_status};

    // A held result stays put while the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Errors always carry a kind, other results never do
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((scan_status == ST_ERR) == (error_kind != ERR_NONE)))
        else $error("status and error kind disagree");

    // Depth never exceeds the stack size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (nest_level <= 4'(MAX_NEST)))
        else $error("nesting depth out of range");

endmodule

FILE: tb/cbor_item_scan_skipper_unit_check.sv
// ----------------------------------------------------------------------------
// cbor_item_scan_skipper_unit_check
// Watches both streams of the CBOR item scanner, predicts each result word
// from the accepted byte words and compares field by field.
// ----------------------------------------------------------------------------
module cbor_item_scan_skipper_unit_check
    import cbor_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {SC_IDLE, SC_HEAD, SC_ARG, SC_SKIP} scan_phase_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  err;
        logic        hdone;
        logic [2:0]  major;
        logic [63:0] arg;
        logic [3:0]  level;
    } scan_result_t;

    scan_result_t expected_q[$];

    scan_phase_t phase;
    logic [63:0] accum;
    logic [3:0]  need_cnt;
    logic [2:0]  held_major;
    logic [31:0] skip_cnt;
    logic [3:0]  depth;
    logic [31:0] children[MAX_NEST_DEF];

    assign pending_count = expected_q.size();

    // Close one child at each open level until a level still has children left
    function automatic logic close_child();
        while (depth > 0) begin
            children[depth-1] = children[depth-1] - 1;
            if (children[depth-1] != 0)
                return 1'b0;
            depth = depth - 1;
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] settle_head(input logic [2:0] mj, input logic [63:0] a,
                                               input logic [15:0] after,
                                               output logic [2:0] err);
        logic [63:0] count;
        count = 0;
        err = ERR_NONE;
        if (mj == MAJ_TAG) begin
            err = ERR_TAG;
            return ST_ERR;
        end
        if (mj == MAJ_BSTR || mj == MAJ_TSTR) begin
            if (a > {48'd0, after}) begin
                err = ERR_TRUNC;
                return ST_ERR;
            end
            if (a != 0) begin
                skip_cnt = a[31:0];
                phase = SC_SKIP;
                return ST_BUSY;
            end
        end else if (mj == MAJ_ARRAY) begin
            if (a > {48'd0, after}) begin
                err = ERR_COUNT;
                return ST_ERR;
            end
            count = a;
        end else if (mj == MAJ_MAP) begin
            if (a > {49'd0, after[15:1]}) begin
                err = ERR_COUNT;
                return ST_ERR;
            end
            count = a * 2;
        end
        if (count != 0) begin
            if (depth >= MAX_NEST_DEF) begin
                err = ERR_DEEP;
                return ST_ERR;
            end
            children[depth] = count[31:0];
            depth = depth + 1;
            phase = SC_HEAD;
            return ST_BUSY;
        end
        phase = SC_HEAD;
        return close_child() ? ST_DONE : ST_BUSY;
    endfunction

    function automatic scan_result_t scan_byte(input logic start, input logic [7:0] b,
                                               input logic [15:0] after);
        scan_result_t r;
        logic [4:0] info;
        logic [3:0] need;
        r = '0;
        if (start) begin
            accum = 0; need_cnt = 0; held_major = 0; skip_cnt = 0; depth = 0;
            phase = SC_HEAD;
        end
        if (phase == SC_IDLE)
            return r;
        r.status = ST_BUSY;
        if (phase == SC_HEAD) begin
            info = b[4:0];
            if (info < INFO_ARG1) begin
                r.hdone = 1; r.major = b[7:5]; r.arg = {59'd0, info};
                r.status = settle_head(b[7:5], {59'd0, info}, after, r.err);
            end else if (info <= INFO_ARG8) begin
                need = 4'd1 << (info - INFO_ARG1);
                if ({12'd0, need} > after) begin
                    r.status = ST_ERR; r.err = ERR_TRUNC;
                end else begin
                    held_major = b[7:5]; accum = 0; need_cnt = need; phase = SC_ARG;
                end
            end else begin
                r.status = ST_ERR; r.err = ERR_INFO;
            end
        end else if (phase == SC_ARG) begin
            accum = {accum[55:0], b};
            need_cnt = need_cnt - 1;
            if (need_cnt == 0) begin
                r.hdone = 1; r.major = held_major; r.arg = accum;
                r.status = settle_head(held_major, accum, after, r.err);
            end
        end else begin
            skip_cnt = skip_cnt - 1;
            if (skip_cnt == 0) begin
                phase = SC_HEAD;
                if (close_child())
                    r.status = ST_DONE;
            end
        end
        if (r.status == ST_BUSY && after == 0) begin
            r.status = ST_ERR; r.err = ERR_TRUNC;
        end
        if (r.status != ST_BUSY)
            phase = SC_IDLE;
        r.level = depth;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n) begin
        scan_result_t e;
        if (!rst_n) begin
            phase = SC_IDLE; accum = 0; need_cnt = 0; held_major = 0;
            skip_cnt = 0; depth = 0;
            for (int i = 0; i < MAX_NEST_DEF; i++)
                children[i] = 0;
            expected_q.delete();
        end else begin
            // Check the result word first, then predict from the byte word
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected word", m_axis_tdata[63:0], 0);
                end else begin
                    e = expected_q.pop_front();
                    if (m_axis_tdata[1:0] != e.status)
                        report("scan_status", m_axis_tdata[1:0], e.status);
                    if (m_axis_tdata[4:2] != e.err)
                        report("error_kind", m_axis_tdata[4:2], e.err);
                    if (m_axis_tuser != e.hdone)
                        report("head_done", m_axis_tuser, e.hdone);
                    if (m_axis_tdata[7:5] != e.major)
                        report("head_major", m_axis_tdata[7:5], e.major);
                    if (m_axis_tdata[71:8] != e.arg)
                        report("head_argument", m_axis_tdata[71:8], e.arg);
                    if (m_axis_tdata[75:72] != e.level)
                        report("nest_level", m_axis_tdata[75:72], e.level);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(scan_byte(s_axis_tuser, s_axis_tdata[7:0],
                                               s_axis_tdata[23:8]));
        end
    end
endmodule

FILE: tb/cbor_item_scan_skipper_unit_test.sv
// ----------------------------------------------------------------------------
// cbor_item_scan_skipper_unit_test
// Drives directed and random CBOR byte streams into the scanner with random
// gaps and stalls on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module cbor_item_scan_skipper_unit_test
    import cbor_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending_count;
    int          cycle_count;
    int          byte_count;
    logic [7:0]  item_buf[$];

    cbor_item_scan_skipper_unit dut (.*);
    cbor_item_scan_skipper_unit_check checker_i (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stall the result side at random
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            m_axis_tready <= 1'b1;
            @(posedge clk);
            stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Send one byte word, hold until accepted, then maybe leave a gap
    task automatic send_byte(input logic start, input logic [7:0] b, input logic [15:0] after);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= {after, b};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        byte_count++;
        gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Append a head with the given argument in the shortest or a chosen form
    task automatic put_head(input logic [2:0] mj, input logic [63:0] a);
        int n;
        if (a < 24 && $urandom_range(0, 5) != 0) begin
            item_buf.push_back({mj, a[4:0]});
            return;
        end
        n = (a < 256) ? 0 : (a < 65536) ? 1 : (a < 64'h1_0000_0000) ? 2 : 3;
        if ($urandom_range(0, 4) == 0 && n < 3) n = n + 1;
        item_buf.push_back({mj, INFO_ARG1 + 5'(n)});
        for (int i = (1 << n) - 1; i >= 0; i--)
            item_buf.push_back(a[i*8 +: 8]);
    endtask

    // Build a well-formed item of limited size and depth
    task automatic build_item(input int lvl);
        int k, len;
        k = $urandom_range(0, 9);
        if (lvl >= 9) k = 0;
        case (k)
            0, 1: put_head(3'($urandom_range(0, 1)),
                           ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                      : 64'($urandom_range(0, 30)));
            2: put_head(3'd7, 64'($urandom_range(0, 23)));
            3, 4: begin
                len = $urandom_range(0, 6);
                put_head(3'($urandom_range(2, 3)), 64'(len));
                repeat (len) item_buf.push_back(8'($urandom));
            end
            5, 6, 7: begin
                len = $urandom_range(0, 3);
                put_head(MAJ_ARRAY, 64'(len));
                repeat (len) build_item(lvl + 1);
            end
            default: begin
                len = $urandom_range(0, 2);
                put_head(MAJ_MAP, 64'(len));
                repeat (2 * len) build_item(lvl + 1);
            end
        endcase
    endtask

    // Send the buffer as one item; bytes_after either exact, padded or short
    task automatic send_buf(input int slack);
        int n, tot;
        n = item_buf.size();
        tot = n + slack;
        if (tot < 1) tot = 1;
        for (int i = 0; i < n && i < tot; i++)
            send_byte(i == 0, item_buf[i], 16'(tot - 1 - i));
        item_buf.delete();
    endtask

    task automatic send_list(input logic [7:0] bytes[], input int slack);
        foreach (bytes[i]) item_buf.push_back(bytes[i]);
        send_buf(slack);
    endtask

    // Hold the input off until every expected result word has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL cbor_item_scan_skipper_unit");
                $finish;
            end
        end
    end

    initial begin
        int r;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        byte_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle byte, small values, immediate and eight-byte arguments, errors
        send_byte(1'b0, 8'hff, 16'hffff);
        send_list('{8'h00}, 0);
        send_list('{8'h17}, 5);
        send_list('{8'h1b, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 0);
        send_list('{8'h19, 8'h12}, 0);                 // argument truncated
        send_list('{8'h1c}, 3);                       // bad additional info
        send_list('{8'hff}, 3);                       // indefinite length
        send_list('{8'hc1, 8'h00}, 0);                // tag
        send_list('{8'h43, 8'h01}, 0);                // string over remaining
        send_list('{8'h84, 8'h01}, 0);                // array count over
        send_list('{8'ha2, 8'h01, 8'h02}, 0);         // map count over
        send_list('{8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h00}, 0);
        send_list('{8'h82, 8'h40}, 1);                // ran out mid array
        send_list('{8'h82, 8'h01}, 2);                // start mid item
        send_list('{8'ha1, 8'h62, 8'h61, 8'h62, 8'hf5}, 0);
        drain();

        // Random: mostly well-formed items, some broken and some noise
        while (byte_count < 1250) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                build_item(0);
                send_buf(($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0);
            end else if (r < 80) begin
                build_item(0);
                send_buf(-$urandom_range(1, 4));
            end else if (r < 90) begin
                build_item(0);
                item_buf[$urandom_range(0, item_buf.size() - 1)] = 8'($urandom);
                send_buf($urandom_range(0, 3));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(1'($urandom), 8'($urandom), 16'($urandom));
            end
            if ($urandom_range(0, 40) == 0) drain();
        end

        // Wind down and let the last result words through
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS cbor_item_scan_skipper_unit");
        else
            $display("FAIL cbor_item_scan_skipper_unit");
        $finish;
    end
endmodule
